// ----- hw/rtl/job_dispatcher_idle_worker_pool_assert.svh -----
// Assertion macros used by the dispatcher datapath.
// Needs a clock named clk and an active-low reset named arst_n in scope.
`ifndef JOB_DISPATCHER_IDLE_WORKER_POOL_ASSERT_SVH
`define JOB_DISPATCHER_IDLE_WORKER_POOL_ASSERT_SVH

// expr must hold at every clock edge outside reset
`define JDIWP_ASSERT_ALWAYS(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// when ante holds, cons must hold in the following cycle
`define JDIWP_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hw/rtl/jdiwp_pkg.sv -----
// Shared types and codes for the job dispatcher.
// No dependencies; imported by the controller, datapath and top level.
package jdiwp_pkg;

	localparam logic [1:0] KIND_SUBMIT = 2'd0;
	localparam logic [1:0] KIND_READY  = 2'd1;
	localparam logic [1:0] KIND_REMOVE = 2'd2;

	typedef struct packed {
		logic [1:0]  kind;
		logic [15:0] job_id;
		logic [2:0]  worker_id;
		logic        worker_finished;
	} evt_item_t;

	typedef struct packed {
		logic        dispatch_valid;
		logic [2:0]  dispatch_worker;
		logic [15:0] dispatch_job;
		logic        completed_valid;
		logic [15:0] completed_job;
		logic        queue_overflow;
		logic [4:0]  jobs_in_flight;
		logic        all_done;
		logic [4:0]  pending_count;
		logic [4:0]  peak_pending;
	} res_item_t;

	typedef enum logic [0:0] {
		ST_IDLE,
		ST_EXEC
	} state_t;

	typedef struct packed {
		logic capture;
		logic execute;
	} dp_cmd_t;

	typedef struct packed {
		logic out_blocked;
	} dp_sts_t;

endpackage

// ----- hw/rtl/jdiwp_ctrl.sv -----
// Controller FSM for the job dispatcher: accept, then execute.
// Uses jdiwp_pkg; drives datapath commands and the input stall.
module jdiwp_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              evt_valid,
	output logic              evt_stall,
	input  jdiwp_pkg::dp_sts_t sts,
	output jdiwp_pkg::dp_cmd_t cmd
);
	import jdiwp_pkg::*;

	state_t state_q, state_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	always_comb begin
		state_n = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (evt_valid) state_n = ST_EXEC;
			end
			ST_EXEC: begin
				// hold the item until the result register is free
				if (!sts.out_blocked) state_n = ST_IDLE;
			end
			default: state_n = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd.capture = (state_q == ST_IDLE) && evt_valid;
		cmd.execute = (state_q == ST_EXEC) && !sts.out_blocked;
		evt_stall   = (state_q != ST_IDLE);
	end

endmodule

// ----- hw/rtl/jdiwp_dp.sv -----
// Datapath of the job dispatcher: worker masks, pending FIFO, held-job store,
// counters and result register. Uses jdiwp_pkg and the assertion macro header.
`include "job_dispatcher_idle_worker_pool_assert.svh"

module jdiwp_dp #(
	parameter int WORKERS     = 8,
	parameter int QUEUE_DEPTH = 16,
	parameter int JOB_ID_BITS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  jdiwp_pkg::dp_cmd_t   cmd,
	output jdiwp_pkg::dp_sts_t   sts,
	input  jdiwp_pkg::evt_item_t evt,
	output logic                 res_valid,
	input  logic                 res_stall,
	output jdiwp_pkg::res_item_t res
);
	import jdiwp_pkg::*;

	localparam int WW = (WORKERS > 1) ? $clog2(WORKERS) : 1;
	localparam int QW = $clog2(QUEUE_DEPTH);
	localparam int FW = $clog2(QUEUE_DEPTH + 1);
	localparam int CW = $clog2(WORKERS + QUEUE_DEPTH + 1);

	// stores
	logic [JOB_ID_BITS-1:0] pend_mem [QUEUE_DEPTH];
	logic [JOB_ID_BITS-1:0] held_mem [WORKERS];
	logic [JOB_ID_BITS-1:0] pend_rd_q, held_rd_q;

	// control state
	logic [WORKERS-1:0] idle_q, busy_q, idle_n, busy_n;
	logic [QW-1:0]      head_q, tail_q, head_n, tail_n;
	logic [FW-1:0]      fill_q, fill_n, peak_q, peak_n;
	logic [CW-1:0]      flight_q, flight_n;

	evt_item_t item_q;
	res_item_t res_q, res_n;
	logic      res_valid_q;

	// execute-cycle write controls
	logic                   held_we, pend_we;
	logic [WW-1:0]          held_wa;
	logic [JOB_ID_BITS-1:0] held_wd, pend_wd;

	// item capture and registered store reads
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			item_q    <= evt;
			held_rd_q <= held_mem[WW'(evt.worker_id)];
		end
		pend_rd_q <= pend_mem[head_q];
		if (held_we) held_mem[held_wa] <= held_wd;
		if (pend_we) pend_mem[tail_q] <= pend_wd;
	end

	always_comb begin
		logic [WW-1:0]          wi;
		logic                   w_ok;
		logic                   place_en;
		logic [JOB_ID_BITS-1:0] place_job;
		logic                   pick_found;
		logic [WW-1:0]          pick_idx;

		wi         = WW'(item_q.worker_id);
		w_ok       = 32'(item_q.worker_id) < WORKERS;
		place_en   = 1'b0;
		place_job  = JOB_ID_BITS'(item_q.job_id);
		pick_found = 1'b0;
		pick_idx   = '0;

		idle_n   = idle_q;
		busy_n   = busy_q;
		head_n   = head_q;
		tail_n   = tail_q;
		fill_n   = fill_q;
		flight_n = flight_q;
		held_we  = 1'b0;
		held_wa  = wi;
		held_wd  = pend_rd_q;
		pend_we  = 1'b0;
		pend_wd  = place_job;
		res_n    = '0;

		unique case (item_q.kind)
			KIND_SUBMIT: begin
				place_en = 1'b1;
			end
			KIND_READY: begin
				if (w_ok) begin
					if (busy_q[wi]) begin
						res_n.completed_valid = 1'b1;
						res_n.completed_job   = 16'(held_rd_q);
						busy_n[wi]            = 1'b0;
						if (flight_n != '0) flight_n = flight_n - CW'(1);
					end
					if (fill_q != '0) begin
						// oldest waiting job goes straight to this worker
						head_n = (head_q == QW'(QUEUE_DEPTH - 1)) ? '0 : head_q + QW'(1);
						fill_n = fill_q - FW'(1);
						idle_n[wi] = 1'b0;
						busy_n[wi] = 1'b1;
						held_we    = 1'b1;
						res_n.dispatch_valid  = 1'b1;
						res_n.dispatch_worker = 3'(wi);
						res_n.dispatch_job    = 16'(pend_rd_q);
					end else begin
						idle_n[wi] = 1'b1;
					end
				end
			end
			KIND_REMOVE: begin
				if (w_ok) begin
					idle_n[wi] = 1'b0;
					if (busy_q[wi]) begin
						busy_n[wi] = 1'b0;
						if (flight_n != '0) flight_n = flight_n - CW'(1);
						if (item_q.worker_finished) begin
							res_n.completed_valid = 1'b1;
							res_n.completed_job   = 16'(held_rd_q);
						end else begin
							place_en  = 1'b1;
							place_job = held_rd_q;
						end
					end
				end
			end
			default: ;
		endcase

		// lowest idle worker
		for (int i = WORKERS - 1; i >= 0; i--) begin
			if (idle_n[i]) begin
				pick_found = 1'b1;
				pick_idx   = WW'(i);
			end
		end

		if (place_en) begin
			if (pick_found) begin
				idle_n[pick_idx] = 1'b0;
				busy_n[pick_idx] = 1'b1;
				held_we  = 1'b1;
				held_wa  = pick_idx;
				held_wd  = place_job;
				flight_n = flight_n + CW'(1);
				res_n.dispatch_valid  = 1'b1;
				res_n.dispatch_worker = 3'(pick_idx);
				res_n.dispatch_job    = 16'(place_job);
			end else if (fill_q < FW'(QUEUE_DEPTH)) begin
				pend_we  = 1'b1;
				pend_wd  = place_job;
				tail_n   = (tail_q == QW'(QUEUE_DEPTH - 1)) ? '0 : tail_q + QW'(1);
				fill_n   = fill_q + FW'(1);
				flight_n = flight_n + CW'(1);
			end else begin
				res_n.queue_overflow = 1'b1;
			end
		end

		peak_n = (fill_n > peak_q) ? fill_n : peak_q;

		res_n.jobs_in_flight = 5'(flight_n);
		res_n.all_done       = (flight_n == '0);
		res_n.pending_count  = 5'(fill_n);
		res_n.peak_pending   = 5'(peak_n);

		if (!cmd.execute) begin
			held_we = 1'b0;
			pend_we = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idle_q   <= '0;
			busy_q   <= '0;
			head_q   <= '0;
			tail_q   <= '0;
			fill_q   <= '0;
			flight_q <= '0;
			peak_q   <= '0;
		end else if (cmd.execute) begin
			idle_q   <= idle_n;
			busy_q   <= busy_n;
			head_q   <= head_n;
			tail_q   <= tail_n;
			fill_q   <= fill_n;
			flight_q <= flight_n;
			peak_q   <= peak_n;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (cmd.execute) begin
			res_valid_q <= 1'b1;
		end else if (res_valid_q && !res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.execute) res_q <= res_n;
	end

	assign sts.out_blocked = res_valid_q && res_stall;
	assign res_valid       = res_valid_q;
	assign res             = res_q;

	`JDIWP_ASSERT_ALWAYS(a_idle_busy_disjoint, (idle_q & busy_q) == '0, "worker both idle and busy")
	`JDIWP_ASSERT_ALWAYS(a_flight_matches, flight_q == CW'(fill_q) + CW'($countones(busy_q)), "in-flight count off")
	`JDIWP_ASSERT_ALWAYS(a_peak_covers_fill, peak_q >= fill_q, "peak below queue fill")
	`JDIWP_ASSERT_NEXT(a_exec_loads_result, cmd.execute, res_valid_q, "result not loaded")

endmodule

// ----- hw/rtl/job_dispatcher_idle_worker_pool.sv -----
// A result is loaded when its item executes, after the item and held-job read
// are registered; execute waits while the previous result is still stalled.
// Items do not overlap: the held-job store and the pending queue memory are read
// into registers before the update, so the next item waits until it completes.
// A stalled result blocks the next update but the next item is still accepted.
// Reset (arst_n low, async) clears masks, pointers and counters; job stores stay
// undefined until written and need no clearing pass.
module job_dispatcher_idle_worker_pool #(
	parameter int WORKERS     = 8,
	parameter int QUEUE_DEPTH = 16,
	parameter int JOB_ID_BITS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 evt_valid,
	output logic                 evt_stall,
	input  jdiwp_pkg::evt_item_t evt,
	output logic                 res_valid,
	input  logic                 res_stall,
	output jdiwp_pkg::res_item_t res
);
	import jdiwp_pkg::*;

	dp_cmd_t cmd;
	dp_sts_t sts;

	jdiwp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.evt_valid (evt_valid),
		.evt_stall (evt_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	jdiwp_dp #(
		.WORKERS     (WORKERS),
		.QUEUE_DEPTH (QUEUE_DEPTH),
		.JOB_ID_BITS (JOB_ID_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.evt       (evt),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res)
	);

endmodule
